[rtl/rmm_pkg.sv]
// Shared types, codes and the CRC-16 byte update for the register read master.
package rmm_pkg;

	// Input command codes
	localparam logic [1:0] CMD_START   = 2'd0;
	localparam logic [1:0] CMD_BYTE    = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	// Result kinds
	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Report status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_HEADER  = 2'd2;
	localparam logic [1:0] ST_CRC     = 2'd3;

	// Protocol constants
	localparam logic [7:0]  FUNC_READ  = 8'h03;
	localparam logic [7:0]  BYTE_COUNT = 8'h02;
	localparam logic [7:0]  QTY_HI     = 8'h00;
	localparam logic [7:0]  QTY_LO     = 8'h01;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	// Reply byte positions
	localparam logic [2:0] RX_ADDR   = 3'd0;
	localparam logic [2:0] RX_FUNC   = 3'd1;
	localparam logic [2:0] RX_COUNT  = 3'd2;
	localparam logic [2:0] RX_VAL_HI = 3'd3;
	localparam logic [2:0] RX_VAL_LO = 3'd4;
	localparam logic [2:0] RX_CRC_LO = 3'd5;
	localparam logic [2:0] RX_CRC_HI = 3'd6;

	// Request frame byte positions
	localparam logic [2:0] TX_ADDR   = 3'd0;
	localparam logic [2:0] TX_FUNC   = 3'd1;
	localparam logic [2:0] TX_REG_HI = 3'd2;
	localparam logic [2:0] TX_REG_LO = 3'd3;
	localparam logic [2:0] TX_QTY_HI = 3'd4;
	localparam logic [2:0] TX_QTY_LO = 3'd5;
	localparam logic [2:0] TX_CRC_LO = 3'd6;
	localparam logic [2:0] TX_CRC_HI = 3'd7;

	// Job queue geometry
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
	localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

	typedef struct packed {
		logic        is_report;
		logic [7:0]  slave_address;
		logic [15:0] register_address;
		logic [1:0]  status;
		logic [15:0] read_value;
	} job_t;

	function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

[rtl/rmm_front.sv]
// Front end: accepts commands, tracks the reply, and queues frame and report jobs.
module rmm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [1:0]         cmd,
	input  logic [7:0]         slave_address,
	input  logic [15:0]        register_address,
	input  logic [7:0]         rx_byte,
	input  logic               q_full,
	output logic               job_push,
	output rmm_pkg::job_t      job
);

	logic        accept;
	logic        phase_q;
	logic [7:0]  expected_address_q;
	logic [2:0]  rx_count_q;
	logic [15:0] running_crc_q;
	logic [15:0] value_shift_q;
	logic        header_bad_q;
	logic [7:0]  crc_low_seen_q;
	logic [15:0] crc_next;
	logic [15:0] crc_got;
	logic [1:0]  reply_status;

	assign accept   = push && !q_full;
	assign crc_next = rmm_pkg::crc16_update(running_crc_q, rx_byte);
	assign crc_got  = {rx_byte, crc_low_seen_q};

	always_comb begin
		if (crc_got != running_crc_q) begin
			reply_status = rmm_pkg::ST_CRC;
		end else if (header_bad_q) begin
			reply_status = rmm_pkg::ST_HEADER;
		end else begin
			reply_status = rmm_pkg::ST_OK;
		end
	end

	always_comb begin
		job_push              = 1'b0;
		job.is_report         = 1'b0;
		job.slave_address     = slave_address;
		job.register_address  = register_address;
		job.status            = rmm_pkg::ST_OK;
		job.read_value        = '0;
		if (accept) begin
			case (cmd)
				rmm_pkg::CMD_START: begin
					job_push = 1'b1;
				end
				rmm_pkg::CMD_TIMEOUT: begin
					if (phase_q) begin
						job_push      = 1'b1;
						job.is_report = 1'b1;
						job.status    = rmm_pkg::ST_TIMEOUT;
					end
				end
				rmm_pkg::CMD_BYTE: begin
					if (phase_q && rx_count_q == rmm_pkg::RX_CRC_HI) begin
						job_push       = 1'b1;
						job.is_report  = 1'b1;
						job.status     = reply_status;
						job.read_value = (reply_status == rmm_pkg::ST_OK) ?
							value_shift_q : 16'h0000;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= 1'b0;
			expected_address_q <= '0;
			rx_count_q         <= '0;
			running_crc_q      <= rmm_pkg::CRC_INIT;
			value_shift_q      <= '0;
			header_bad_q       <= 1'b0;
			crc_low_seen_q     <= '0;
		end else if (accept) begin
			case (cmd)
				rmm_pkg::CMD_START: begin
					// restart abandons any pending reply
					phase_q            <= 1'b1;
					expected_address_q <= slave_address;
					rx_count_q         <= '0;
					running_crc_q      <= rmm_pkg::CRC_INIT;
					value_shift_q      <= '0;
					header_bad_q       <= 1'b0;
					crc_low_seen_q     <= '0;
				end
				rmm_pkg::CMD_TIMEOUT: begin
					phase_q <= 1'b0;
				end
				rmm_pkg::CMD_BYTE: begin
					if (phase_q) begin
						case (rx_count_q) inside
							rmm_pkg::RX_ADDR: begin
								if (rx_byte != expected_address_q) header_bad_q <= 1'b1;
							end
							rmm_pkg::RX_FUNC: begin
								if (rx_byte != rmm_pkg::FUNC_READ) header_bad_q <= 1'b1;
							end
							rmm_pkg::RX_COUNT: begin
								if (rx_byte != rmm_pkg::BYTE_COUNT) header_bad_q <= 1'b1;
							end
							rmm_pkg::RX_VAL_HI, rmm_pkg::RX_VAL_LO: begin
								value_shift_q <= {value_shift_q[7:0], rx_byte};
							end
							rmm_pkg::RX_CRC_LO: begin
								crc_low_seen_q <= rx_byte;
							end
							default: begin
							end
						endcase
						if (rx_count_q < rmm_pkg::RX_CRC_LO) begin
							running_crc_q <= crc_next;
						end
						if (rx_count_q == rmm_pkg::RX_CRC_HI) begin
							phase_q    <= 1'b0;
							rx_count_q <= '0;
						end else begin
							rx_count_q <= rx_count_q + 3'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/rmm_jobq.sv]
// Short job queue between the front end and the back end.
module rmm_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  rmm_pkg::job_t wr_job,
	input  logic          rd_en,
	output rmm_pkg::job_t rd_job,
	output logic          full,
	output logic          empty
);

	rmm_pkg::job_t                  mem_q [rmm_pkg::JOBQ_DEPTH];
	logic [rmm_pkg::JOBQ_AW-1:0]    wr_ptr_q;
	logic [rmm_pkg::JOBQ_AW-1:0]    rd_ptr_q;
	logic [rmm_pkg::JOBQ_CW-1:0]    count_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full   = (count_q == rmm_pkg::JOBQ_CW'(rmm_pkg::JOBQ_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + rmm_pkg::JOBQ_AW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + rmm_pkg::JOBQ_AW'(1);
			if (do_wr && !do_rd) begin
				count_q <= count_q + rmm_pkg::JOBQ_CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - rmm_pkg::JOBQ_CW'(1);
			end
		end
	end

endmodule

[rtl/rmm_back.sv]
// Back end: expands frame jobs into request bytes and registers results for the consumer.
module rmm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  rmm_pkg::job_t q_job,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output logic          kind,
	output logic [7:0]    tx_byte,
	output logic          tx_last,
	output logic [1:0]    status,
	output logic [15:0]   read_value
);

	logic        out_valid_q;
	logic        busy_q;
	logic [2:0]  idx_q;
	logic [7:0]  addr_q;
	logic [15:0] reg_q;
	logic [15:0] crc_q;
	logic        out_free;
	logic        emit_tx;
	logic        emit_rep;
	logic        load;
	logic [7:0]  frame_byte;

	assign out_free = !out_valid_q || pop;
	assign q_pop    = !busy_q && !q_empty && out_free;
	assign emit_tx  = busy_q && out_free;
	assign emit_rep = q_pop && q_job.is_report;
	assign load     = q_pop && !q_job.is_report;
	assign empty    = !out_valid_q;

	always_comb begin
		case (idx_q)
			rmm_pkg::TX_ADDR:   frame_byte = addr_q;
			rmm_pkg::TX_FUNC:   frame_byte = rmm_pkg::FUNC_READ;
			rmm_pkg::TX_REG_HI: frame_byte = reg_q[15:8];
			rmm_pkg::TX_REG_LO: frame_byte = reg_q[7:0];
			rmm_pkg::TX_QTY_HI: frame_byte = rmm_pkg::QTY_HI;
			rmm_pkg::TX_QTY_LO: frame_byte = rmm_pkg::QTY_LO;
			rmm_pkg::TX_CRC_LO: frame_byte = crc_q[7:0];
			default:            frame_byte = crc_q[15:8];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (out_free) out_valid_q <= emit_tx || emit_rep;
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit_tx) begin
				if (idx_q == rmm_pkg::TX_CRC_HI) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= q_job.slave_address;
			reg_q  <= q_job.register_address;
			crc_q  <= rmm_pkg::CRC_INIT;
		end else if (emit_tx && idx_q < rmm_pkg::TX_CRC_LO) begin
			// fold each header byte into the frame CRC as it goes out
			crc_q <= rmm_pkg::crc16_update(crc_q, frame_byte);
		end
		if (emit_tx) begin
			kind       <= rmm_pkg::KIND_TX;
			tx_byte    <= frame_byte;
			tx_last    <= (idx_q == rmm_pkg::TX_CRC_HI);
			status     <= rmm_pkg::ST_OK;
			read_value <= '0;
		end else if (emit_rep) begin
			kind       <= rmm_pkg::KIND_REPORT;
			tx_byte    <= '0;
			tx_last    <= 1'b0;
			status     <= q_job.status;
			read_value <= q_job.read_value;
		end
	end

endmodule

[rtl/modbus_rtu_register_read_master.sv]
// Top level of the Modbus RTU holding register read master.
//
// Input queue: drive cmd and its fields with push; an item is taken when push
// is high and full is low. cmd start sends a read request for slave_address and
// register_address, cmd byte delivers one received reply byte (rx_byte), cmd
// timeout ends a pending reply. Bytes and timeouts while idle are dropped.
// Result queue: while empty is low the oldest result sits on kind, tx_byte,
// tx_last, status and read_value; pop takes it. A start yields eight transmit
// bytes (tx_last on the eighth); the seventh reply byte or a timeout yields one
// report with status and value.
// Throughput: one input item per cycle while the four-entry job queue has room.
// A request frame leaves the back end at one byte per cycle while the consumer
// keeps taking results, after its job is loaded; a report is registered from
// the job queue head. The byte sequencer and the queue depth set these rates.
// When the consumer holds pop low the output register holds its result, the
// back end stops, the queue fills and full rises. Reset clears all control
// state: the master comes up idle with both queues empty.
module modbus_rtu_register_read_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [7:0]  slave_address,
	input  logic [15:0] register_address,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic        tx_last,
	output logic [1:0]  status,
	output logic [15:0] read_value
);

	logic          job_push;
	rmm_pkg::job_t job_in;
	rmm_pkg::job_t job_out;
	logic          q_pop;
	logic          q_empty;
	logic          q_full;

	assign full = q_full;

	rmm_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.cmd              (cmd),
		.slave_address    (slave_address),
		.register_address (register_address),
		.rx_byte          (rx_byte),
		.q_full           (q_full),
		.job_push         (job_push),
		.job              (job_in)
	);

	rmm_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job_in),
		.rd_en  (q_pop),
		.rd_job (job_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	rmm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (job_out),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.kind       (kind),
		.tx_byte    (tx_byte),
		.tx_last    (tx_last),
		.status     (status),
		.read_value (read_value)
	);

endmodule
